// ----- hw/rtl/pmst_pkg.sv -----
// Shared constants and types for the Prim spanning-tree block.
package pmst_pkg;

  localparam int MAX_V  = 32;
  localparam int VID_W  = $clog2(MAX_V);
  localparam int CNT_W  = VID_W + 1;
  localparam int WB     = 16;
  localparam int CW     = WB + 1;
  localparam int ADDR_W = 2 * VID_W;
  localparam int TOT_W  = 21;

  localparam logic [CW-1:0]    NO_EDGE   = {1'b1, {WB{1'b0}}};
  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  localparam logic CFG_VCOUNT = 1'b0;
  localparam logic CFG_START  = 1'b1;
  localparam logic OP_LOAD    = 1'b0;

  typedef struct packed {
    logic [CW-1:0]    cost;
    logic [VID_W-1:0] from;
    logic             in_tree;
  } cell_t;

endpackage

// ----- hw/rtl/pmst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pmst_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pmst_cell.sv -----
// One vertex cell of the rotating cost ring.
module pmst_cell (
  input  logic           clk,
  input  logic           shift,
  input  pmst_pkg::cell_t din,
  output pmst_pkg::cell_t dout
);

  pmst_pkg::cell_t data_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= din;
    end
  end

  assign dout = data_r;

endmodule

// ----- hw/rtl/prim_min_spanning_tree.sv -----
// Top level: Prim spanning tree over an adjacency RAM with a ring of vertex cells.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | op, row, col, weight, present
//   out_    | output    | out_valid/out_stall| from/to vertex, weight, total, flags
//   cfg_    | input     | cfg_valid/cfg_ready| index, data
//
// After reset a clearing pass writes "no edge" into all 1024 RAM entries
// while in_stall stays high; config writes are taken throughout.
// A load item makes one RAM write per direction.
// A run item is accepted and then makes n-1 passes (PREP, a shift of all 32
// ring cells past the head, which reads one RAM word per cycle, and DONE),
// and returns n-1 items; a pass waits in DONE while the output register is
// full. A run with one vertex stays in IDLE and returns nothing.
module prim_min_spanning_tree (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [pmst_pkg::VID_W-1:0]  in_row,
  input  logic [pmst_pkg::VID_W-1:0]  in_col,
  input  logic [pmst_pkg::WB-1:0]     in_weight,
  input  logic                        in_present,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pmst_pkg::VID_W-1:0]  out_from_vertex,
  output logic [pmst_pkg::VID_W-1:0]  out_to_vertex,
  output logic [pmst_pkg::WB-1:0]     out_edge_weight,
  output logic [pmst_pkg::TOT_W-1:0]  out_running_total,
  output logic                        out_connected,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [5:0]                  cfg_data
);

  typedef enum logic [2:0] {CLEAR, IDLE, LOAD2, PREP, PASS, DONE} state_t;

  state_t state_r;

  logic [pmst_pkg::CNT_W-1:0]  vcount_r;
  logic [pmst_pkg::VID_W-1:0]  start_r;
  logic [pmst_pkg::CNT_W-1:0]  n_r;
  logic [pmst_pkg::VID_W-1:0]  s_r;
  logic                        init_r;
  logic [pmst_pkg::VID_W-1:0]  k_r;
  logic [pmst_pkg::VID_W-1:0]  cnt_r;
  logic [pmst_pkg::CNT_W-1:0]  round_r;
  logic [pmst_pkg::ADDR_W-1:0] clr_r;
  logic [pmst_pkg::ADDR_W-1:0] laddr_r;
  logic [pmst_pkg::CW-1:0]     lw_r;
  logic [pmst_pkg::TOT_W-1:0]  total_r;

  // best candidate of the current pass
  logic                        found_r;
  logic [pmst_pkg::VID_W-1:0]  bk_r;
  logic [pmst_pkg::CW-1:0]     bc_r;
  logic [pmst_pkg::VID_W-1:0]  bf_r;

  // RAM ports
  logic                        we;
  logic [pmst_pkg::ADDR_W-1:0] waddr;
  logic [pmst_pkg::CW-1:0]     wdata;
  logic [pmst_pkg::ADDR_W-1:0] raddr;
  logic [pmst_pkg::CW-1:0]     rdata;

  pmst_ram #(.W(pmst_pkg::CW), .D(pmst_pkg::MAX_V * pmst_pkg::MAX_V)) u_adj (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ring of cells: cell 0 is the head, the processed head re-enters at the tail
  pmst_pkg::cell_t ring [pmst_pkg::MAX_V];
  pmst_pkg::cell_t head_nxt;
  logic            shift;

  for (genvar g = 0; g < pmst_pkg::MAX_V; g++) begin : g_cell
    pmst_pkg::cell_t din;
    if (g == pmst_pkg::MAX_V - 1) begin : g_tail
      assign din = head_nxt;
    end else begin : g_mid
      assign din = ring[g+1];
    end
    pmst_cell u_cell (.clk(clk), .shift(shift), .din(din), .dout(ring[g]));
  end

  assign shift = (state_r == PASS);

  // head update: seed on the first pass, relax through k on later passes
  always_comb begin
    head_nxt = ring[0];
    if (init_r) begin
      head_nxt.cost    = rdata;
      head_nxt.from    = s_r;
      head_nxt.in_tree = (cnt_r == s_r) || ({1'b0, cnt_r} >= n_r);
    end else begin
      head_nxt.in_tree = ring[0].in_tree || (cnt_r == k_r);
      if (!head_nxt.in_tree && rdata < ring[0].cost) begin
        head_nxt.cost = rdata;
        head_nxt.from = k_r;
      end
    end
  end

  logic take_cand;
  assign take_cand = !head_nxt.in_tree && (!found_r || head_nxt.cost < bc_r);

  logic in_acc, out_free;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != IDLE);
  assign cfg_ready = 1'b1;

  // clamped run geometry
  logic [pmst_pkg::CNT_W-1:0] n_eff;
  logic [pmst_pkg::VID_W-1:0] s_eff;
  always_comb begin
    priority if (vcount_r == '0) begin
      n_eff = pmst_pkg::CNT_W'(1);
    end else if (vcount_r > pmst_pkg::CNT_W'(pmst_pkg::MAX_V)) begin
      n_eff = pmst_pkg::CNT_W'(pmst_pkg::MAX_V);
    end else begin
      n_eff = vcount_r;
    end
    s_eff = ({1'b0, start_r} >= n_eff) ? '0 : start_r;
  end

  // result of a finished pass
  logic                          conn;
  logic [pmst_pkg::TOT_W:0]      sum;
  logic [pmst_pkg::TOT_W-1:0]    tot_nxt;
  assign conn    = !bc_r[pmst_pkg::WB];
  assign sum     = {1'b0, total_r} + (pmst_pkg::TOT_W+1)'(bc_r[pmst_pkg::WB-1:0]);
  assign tot_nxt = !conn ? total_r :
                   (sum[pmst_pkg::TOT_W] ? pmst_pkg::TOTAL_MAX : sum[pmst_pkg::TOT_W-1:0]);

  // RAM port selection
  always_comb begin
    we    = 1'b0;
    waddr = laddr_r;
    wdata = lw_r;
    raddr = {k_r, cnt_r + pmst_pkg::VID_W'(1)};
    unique case (state_r)
      CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = pmst_pkg::NO_EDGE;
      end
      IDLE: begin
        we    = in_acc && (in_op == pmst_pkg::OP_LOAD);
        waddr = {in_row, in_col};
        wdata = in_present ? {1'b0, in_weight} : pmst_pkg::NO_EDGE;
      end
      LOAD2: begin
        we = 1'b1;
      end
      PREP: begin
        raddr = {k_r, {pmst_pkg::VID_W{1'b0}}};
      end
      PASS, DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CLEAR;
      clr_r     <= '0;
      vcount_r  <= pmst_pkg::CNT_W'(1);
      start_r   <= '0;
      out_valid <= 1'b0;
      found_r   <= 1'b0;
      total_r   <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pmst_pkg::CFG_VCOUNT: vcount_r <= cfg_data;
          pmst_pkg::CFG_START:  start_r  <= cfg_data[pmst_pkg::VID_W-1:0];
          default: begin
          end
        endcase
      end
      // drop the taken result unless DONE refills the register this cycle
      if (out_valid && !out_stall && state_r != DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        CLEAR: begin
          clr_r <= clr_r + pmst_pkg::ADDR_W'(1);
          if (clr_r == {pmst_pkg::ADDR_W{1'b1}}) begin
            state_r <= IDLE;
          end
        end
        IDLE: begin
          if (in_acc) begin
            if (in_op == pmst_pkg::OP_LOAD) begin
              laddr_r <= {in_col, in_row};
              lw_r    <= in_present ? {1'b0, in_weight} : pmst_pkg::NO_EDGE;
              state_r <= LOAD2;
            end else begin
              n_r     <= n_eff;
              s_r     <= s_eff;
              k_r     <= s_eff;
              init_r  <= 1'b1;
              round_r <= pmst_pkg::CNT_W'(1);
              total_r <= '0;
              if (n_eff != pmst_pkg::CNT_W'(1)) begin
                state_r <= PREP;
              end
            end
          end
        end
        LOAD2: begin
          state_r <= IDLE;
        end
        PREP: begin
          cnt_r   <= '0;
          found_r <= 1'b0;
          state_r <= PASS;
        end
        PASS: begin
          cnt_r <= cnt_r + pmst_pkg::VID_W'(1);
          if (take_cand) begin
            found_r <= 1'b1;
            bk_r    <= cnt_r;
            bc_r    <= head_nxt.cost;
            bf_r    <= head_nxt.from;
          end
          if (cnt_r == pmst_pkg::VID_W'(pmst_pkg::MAX_V - 1)) begin
            state_r <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_from_vertex   <= bf_r;
            out_to_vertex     <= bk_r;
            out_edge_weight   <= conn ? bc_r[pmst_pkg::WB-1:0] : '0;
            out_running_total <= tot_nxt;
            out_connected     <= conn;
            out_last          <= (round_r == n_r - pmst_pkg::CNT_W'(1));
            total_r           <= tot_nxt;
            k_r               <= bk_r;
            init_r            <= 1'b0;
            round_r           <= round_r + pmst_pkg::CNT_W'(1);
            state_r           <= (round_r == n_r - pmst_pkg::CNT_W'(1)) ? IDLE : PREP;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  // a pass always leaves at least one vertex outside the tree
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == DONE |-> found_r) else $error("pass ended without a candidate");

  // no result can come out while the RAM is still being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CLEAR |-> !out_valid) else $error("result during clearing pass");

  // a pass runs to its end without interruption
  a_pass_flow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == PASS |=> state_r == PASS || state_r == DONE)
    else $error("pass interrupted");

  // a result is loaded only from DONE with a free output register
  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == DONE) else $error("stray result");

endmodule
